@@ rtl/lph_pkg.sv @@
// Shared types and constants for the linear probing hash map.
// No dependencies; imported by linear_probe_hash_map, lph_hash and the bench.
package lph_pkg;

    localparam int FUNC_W = 2;
    localparam int KEY_W  = 32;
    localparam int VAL_W  = 32;
    localparam int LIVE_W = 7;

    localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_FIND   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd2;

    // slot state codes; code 3 is never written and behaves as deleted
    localparam logic [1:0] SLOT_EMPTY   = 2'd0;
    localparam logic [1:0] SLOT_DELETED = 2'd1;
    localparam logic [1:0] SLOT_LIVE    = 2'd2;

    typedef struct packed {
        logic [1:0]       st;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } t_slot;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_PROBE,
        S_WAIT
    } t_state;

endpackage

@@ rtl/linear_probe_hash_map.sv @@
// Open-addressing key/value table with linear probing and tombstones. Slot
// state, key and value share one RAM with a registered read. After reset a
// clearing pass marks every slot empty; no word is taken meanwhile. Each word
// is then captured, its home slot is found (reciprocal multiplication, or a
// mask when TABLE_SIZE is a power of two), the home slot is read from the RAM,
// then one slot is compared per cycle until the probe ends (at most TABLE_SIZE
// slots), and the result goes to the output register once it is free. The
// probe walk, one RAM read per slot, sets the worst case. Insert stops at the
// first non-live slot or the key's slot; find and remove stop at the first live
// slot with the key. live_entries carries the low 7 bits of the live count.
module linear_probe_hash_map #(
    parameter int TABLE_SIZE = 64
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [lph_pkg::FUNC_W-1:0]       i_func,
    input  logic [lph_pkg::KEY_W-1:0]        i_key,
    input  logic signed [lph_pkg::VAL_W-1:0] i_value,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic                             o_success,
    output logic                             o_table_full,
    output logic signed [lph_pkg::VAL_W-1:0] o_found_value,
    output logic [lph_pkg::LIVE_W-1:0]       o_live_entries
);
    import lph_pkg::*;

    localparam int IDX_W = $clog2(TABLE_SIZE);
    localparam int CNT_W = $clog2(TABLE_SIZE + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SIZE - 1);

    t_state           r_state, n_state;
    logic [FUNC_W-1:0] r_func, n_func;
    logic [KEY_W-1:0] r_key, n_key;
    logic [VAL_W-1:0] r_value, n_value;
    logic [IDX_W-1:0] r_clr_idx, n_clr_idx;
    logic [IDX_W-1:0] r_rd_idx, n_rd_idx;
    logic [IDX_W-1:0] r_eval_idx, n_eval_idx;
    logic             r_rd_vld, n_rd_vld;
    logic [IDX_W-1:0] r_cnt, n_cnt;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_res_success, n_res_success;
    logic             r_res_full, n_res_full;
    logic [VAL_W-1:0] r_res_found, n_res_found;

    logic              r_out_valid;
    logic              r_out_success;
    logic              r_out_full;
    logic [VAL_W-1:0]  r_out_found;
    logic [LIVE_W-1:0] r_out_live;

    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    t_slot            ram_wdata;
    t_slot            ram_rdata;
    logic             hash_start;
    logic             hash_done;
    logic [IDX_W-1:0] hash_home;
    logic             out_load;
    logic             key_hit;
    logic             is_live;
    logic             last_slot;
    logic             probe_done;
    logic [IDX_W-1:0] next_idx;

    lph_ram #(
        .WIDTH ($bits(t_slot)),
        .DEPTH (TABLE_SIZE)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (1'b1),
        .i_raddr (r_rd_idx),
        .o_rdata (ram_rdata)
    );

    lph_hash #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (hash_start),
        .i_key   (i_key),
        .o_done  (hash_done),
        .o_home  (hash_home)
    );

    assign key_hit   = ram_rdata.key == r_key;
    assign is_live   = ram_rdata.st == SLOT_LIVE;
    assign last_slot = r_cnt == LAST_IDX;
    assign next_idx  = (r_rd_idx == LAST_IDX) ? '0 : r_rd_idx + IDX_W'(1);

    assign o_in_stall = r_state != S_IDLE;

    always_comb begin
        n_state       = r_state;
        n_func        = r_func;
        n_key         = r_key;
        n_value       = r_value;
        n_clr_idx     = r_clr_idx;
        n_rd_idx      = r_rd_idx;
        n_eval_idx    = r_eval_idx;
        n_rd_vld      = r_rd_vld;
        n_cnt         = r_cnt;
        n_count       = r_count;
        n_res_success = r_res_success;
        n_res_full    = r_res_full;
        n_res_found   = r_res_found;
        ram_we        = 1'b0;
        ram_waddr     = r_eval_idx;
        ram_wdata     = '0;
        hash_start    = 1'b0;
        out_load      = 1'b0;
        probe_done    = 1'b0;

        case (r_state)
            S_CLEAR: begin
                ram_we       = 1'b1;
                ram_waddr    = r_clr_idx;
                ram_wdata.st = SLOT_EMPTY;
                n_clr_idx    = r_clr_idx + IDX_W'(1);
                if (r_clr_idx == LAST_IDX) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_func     = i_func;
                    n_key      = i_key;
                    n_value    = i_value;
                    hash_start = 1'b1;
                    n_state    = S_HASH;
                end
            end
            S_HASH: begin
                if (hash_done) begin
                    n_rd_idx = hash_home;
                    n_rd_vld = 1'b0;
                    n_cnt    = '0;
                    n_state  = S_PROBE;
                end
            end
            S_PROBE: begin
                // reads run one slot ahead of the compare
                n_rd_vld   = 1'b1;
                n_eval_idx = r_rd_idx;
                n_rd_idx   = next_idx;
                if (r_rd_vld) begin
                    n_res_success = 1'b0;
                    n_res_full    = 1'b0;
                    n_res_found   = '0;
                    case (r_func)
                        FUNC_INSERT: begin
                            if (!is_live) begin
                                ram_we          = 1'b1;
                                ram_wdata.st    = SLOT_LIVE;
                                ram_wdata.key   = r_key;
                                ram_wdata.value = r_value;
                                n_count         = r_count + CNT_W'(1);
                                n_res_success   = 1'b1;
                                probe_done      = 1'b1;
                            end else if (key_hit) begin
                                probe_done = 1'b1;
                            end else if (last_slot) begin
                                n_res_full = 1'b1;
                                probe_done = 1'b1;
                            end
                        end
                        FUNC_FIND: begin
                            if (is_live && key_hit) begin
                                n_res_success = 1'b1;
                                n_res_found   = ram_rdata.value;
                                probe_done    = 1'b1;
                            end else if (last_slot) begin
                                probe_done = 1'b1;
                            end
                        end
                        FUNC_REMOVE: begin
                            if (is_live && key_hit) begin
                                ram_we          = 1'b1;
                                ram_wdata.st    = SLOT_DELETED;
                                ram_wdata.key   = ram_rdata.key;
                                ram_wdata.value = ram_rdata.value;
                                if (r_count != '0) begin
                                    n_count = r_count - CNT_W'(1);
                                end
                                n_res_success = 1'b1;
                                probe_done    = 1'b1;
                            end else if (last_slot) begin
                                probe_done = 1'b1;
                            end
                        end
                        default: begin
                            probe_done = 1'b1;
                        end
                    endcase
                    if (probe_done) begin
                        n_state = S_WAIT;
                    end else begin
                        n_cnt = r_cnt + IDX_W'(1);
                    end
                end
            end
            S_WAIT: begin
                if (!r_out_valid || !i_out_stall) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr_idx <= '0;
            r_rd_vld  <= 1'b0;
            r_cnt     <= '0;
            r_count   <= '0;
        end else begin
            r_state   <= n_state;
            r_clr_idx <= n_clr_idx;
            r_rd_vld  <= n_rd_vld;
            r_cnt     <= n_cnt;
            r_count   <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func        <= n_func;
        r_key         <= n_key;
        r_value       <= n_value;
        r_rd_idx      <= n_rd_idx;
        r_eval_idx    <= n_eval_idx;
        r_res_success <= n_res_success;
        r_res_full    <= n_res_full;
        r_res_found   <= n_res_found;
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_success <= r_res_success;
            r_out_full    <= r_res_full;
            r_out_found   <= r_res_found;
            r_out_live    <= LIVE_W'(r_count);
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_success      = r_out_success;
    assign o_table_full   = r_out_full;
    assign o_found_value  = r_out_found;
    assign o_live_entries = r_out_live;

endmodule

@@ rtl/lph_ram.sv @@
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module lph_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/lph_hash.sv @@
// Home slot unit: key modulo the table size. A mask when the size is a power
// of two, otherwise a registered reciprocal multiplication. Uses lph_pkg.
module lph_hash #(
    parameter int TABLE_SIZE = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [lph_pkg::KEY_W-1:0]     i_key,
    output logic                          o_done,
    output logic [$clog2(TABLE_SIZE)-1:0] o_home
);
    import lph_pkg::*;

    localparam int  IDX_W   = $clog2(TABLE_SIZE);
    localparam bit  IS_POW2 = (TABLE_SIZE & (TABLE_SIZE - 1)) == 0;

    logic             r_done;
    logic [IDX_W-1:0] r_rem;

    generate
        if (IS_POW2) begin : g_mask
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_done <= 1'b0;
                end else begin
                    r_done <= i_start;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_start) begin
                    r_rem <= i_key[IDX_W-1:0];
                end
            end
        end else begin : g_recip
            localparam int RCP_W  = KEY_W + 1;
            localparam int PROD_W = KEY_W + RCP_W;
            localparam int SHIFT  = KEY_W + IDX_W;
            // ceil(2^SHIFT / size): the quotient is exact for every key
            localparam logic [RCP_W-1:0] RECIP =
                RCP_W'(((64'd1 << SHIFT) / TABLE_SIZE) + 64'd1);
            localparam logic [IDX_W-1:0] SIZE_LO = IDX_W'(TABLE_SIZE);

            logic               r_mul_go;
            logic               r_sub_go;
            logic [KEY_W-1:0]   r_k;
            logic [IDX_W-1:0]   r_q;
            logic [PROD_W-1:0]  prod;
            logic [2*IDX_W-1:0] qn;

            assign prod = PROD_W'(r_k) * PROD_W'(RECIP);
            // remainder fits in IDX_W bits, so only the low quotient bits matter
            assign qn   = (2*IDX_W)'(r_q) * (2*IDX_W)'(SIZE_LO);

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_mul_go <= 1'b0;
                    r_sub_go <= 1'b0;
                    r_done   <= 1'b0;
                end else begin
                    r_mul_go <= i_start;
                    r_sub_go <= r_mul_go;
                    r_done   <= r_sub_go;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_start) begin
                    r_k <= i_key;
                end
                if (r_mul_go) begin
                    r_q <= prod[SHIFT +: IDX_W];
                end
                if (r_sub_go) begin
                    r_rem <= r_k[IDX_W-1:0] - qn[IDX_W-1:0];
                end
            end
        end
    endgenerate

    assign o_done = r_done;
    assign o_home = r_rem;

endmodule

@@ tb/linear_probe_hash_map_test.sv @@
`timescale 1ns / 100ps
// Self-checking bench for linear_probe_hash_map: a short directed run of corner
// cases, then phased random traffic, checked against an in-bench table model.
// Needs rtl/lph_pkg.sv, rtl/lph_ram.sv, rtl/lph_hash.sv and rtl/linear_probe_hash_map.sv.
module linear_probe_hash_map_test;
    import lph_pkg::*;

    localparam int CLK_PERIOD  = 12;
    localparam int TBL         = 64;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int TAIL_CYCLES = 200;
    localparam int MAX_REPORTS = 200;
    localparam int KNOWN_MAX   = 96;

    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [KEY_W-1:0]  key;
        logic [VAL_W-1:0]  value;
    } t_op;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              success;
        logic              table_full;
        logic [VAL_W-1:0]  found_value;
        logic [LIVE_W-1:0] live_entries;
    } t_reply;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_stall;
    logic [FUNC_W-1:0]        i_func = '0;
    logic [KEY_W-1:0]         i_key = '0;
    logic signed [VAL_W-1:0]  i_value = '0;
    logic                     o_out_valid;
    logic                     i_out_stall = 1'b0;
    logic                     o_success;
    logic                     o_table_full;
    logic signed [VAL_W-1:0]  o_found_value;
    logic [LIVE_W-1:0]        o_live_entries;

    // table model
    logic [1:0]       slot_st [TBL];
    logic [KEY_W-1:0] slot_k  [TBL];
    logic [VAL_W-1:0] slot_v  [TBL];
    int               live_cnt;

    t_op              op_backlog[$];
    t_reply           pending_results[$];
    logic [KEY_W-1:0] known_keys[$];
    t_op              held_word;
    t_reply           fresh;

    int words_queued = 0;
    int words_accepted = 0;
    int in_idle_pct = 0;
    int out_idle_pct = 0;
    int in_gap_left = 0;
    int out_gap_left = 0;
    int errors = 0;
    int cycle_count = 0;
    int n_checked = 0;
    int n_ins = 0, n_dup = 0, n_full = 0, n_find = 0, n_rem = 0, n_unused = 0;
    int peak_live = 0;

    linear_probe_hash_map #(
        .TABLE_SIZE(TBL)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_func        (i_func),
        .i_key         (i_key),
        .i_value       (i_value),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_success     (o_success),
        .o_table_full  (o_table_full),
        .o_found_value (o_found_value),
        .o_live_entries(o_live_entries)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Applies one word to the model table and returns the reply it should give.
    function automatic t_reply table_apply(input t_op w);
        t_reply r;
        int     idx;
        bit     hit;
        r = '0;
        r.func = w.func;
        idx = w.key % TBL;
        hit = 1'b0;
        case (w.func)
            FUNC_INSERT: begin
                r.table_full = 1'b1;
                for (int n = 0; n < TBL && !hit; n++) begin
                    if (slot_st[idx] != SLOT_LIVE) begin
                        slot_st[idx] = SLOT_LIVE;
                        slot_k[idx] = w.key;
                        slot_v[idx] = w.value;
                        live_cnt++;
                        r.success = 1'b1;
                        r.table_full = 1'b0;
                        hit = 1'b1;
                    end else if (slot_k[idx] == w.key) begin
                        r.table_full = 1'b0;
                        hit = 1'b1;
                    end else begin
                        idx = (idx + 1) % TBL;
                    end
                end
            end
            FUNC_FIND, FUNC_REMOVE: begin
                // first live copy met from home wins
                for (int n = 0; n < TBL && !hit; n++) begin
                    if (slot_st[idx] == SLOT_LIVE && slot_k[idx] == w.key)
                        hit = 1'b1;
                    else
                        idx = (idx + 1) % TBL;
                end
                if (hit) begin
                    r.success = 1'b1;
                    if (w.func == FUNC_FIND) begin
                        r.found_value = slot_v[idx];
                    end else begin
                        slot_st[idx] = SLOT_DELETED;
                        if (live_cnt > 0)
                            live_cnt--;
                    end
                end
            end
            default: ;
        endcase
        r.live_entries = live_cnt[LIVE_W-1:0];
        return r;
    endfunction

    task automatic queue_word(input logic [FUNC_W-1:0] func, input logic [KEY_W-1:0] key,
                              input logic [VAL_W-1:0] value);
        t_op w;
        w.func = func;
        w.key = key;
        w.value = value;
        if (func == FUNC_INSERT) begin
            if (known_keys.size() >= KNOWN_MAX)
                known_keys.delete($urandom_range(0, known_keys.size() - 1));
            known_keys.push_back(key);
        end
        op_backlog.push_back(w);
        words_queued++;
    endtask

    // Mostly keys seen before (hits, duplicates, keys behind tombstones),
    // otherwise fresh keys whose home falls in the chosen window.
    function automatic logic [KEY_W-1:0] pick_key(input int home_lo, input int home_span);
        logic [KEY_W-1:0] k;
        int               home;
        k = $urandom;
        home = (home_lo + $urandom_range(0, home_span - 1)) % TBL;
        if (known_keys.size() != 0 && $urandom_range(0, 2) != 0)
            k = known_keys[$urandom_range(0, known_keys.size() - 1)];
        else if (home_span < TBL)
            k[5:0] = home[5:0];
        return k;
    endfunction

    function automatic logic [VAL_W-1:0] pick_value();
        logic [VAL_W-1:0] v;
        v = $urandom;
        if ($urandom_range(0, 15) == 0) begin
            case ($urandom_range(0, 3))
                0: v = 32'h7FFF_FFFF;
                1: v = 32'h8000_0000;
                2: v = 32'h0000_0000;
                default: v = 32'hFFFF_FFFF;
            endcase
        end
        return v;
    endfunction

    task automatic wait_all_answered();
        while (words_accepted != words_queued || pending_results.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic run_phase(input int n_words, input int home_lo, input int home_span,
                             input int ins_pct, input int rem_pct,
                             input int in_idle, input int out_idle);
        int               roll;
        logic [FUNC_W-1:0] f;
        while (op_backlog.size() != 0)
            @(negedge i_clk);
        in_idle_pct = in_idle;
        out_idle_pct = out_idle;
        for (int i = 0; i < n_words; i++) begin
            roll = $urandom_range(0, 99);
            if (roll < 2)
                f = FUNC_UNUSED;
            else if (roll < 2 + ins_pct)
                f = FUNC_INSERT;
            else if (roll < 2 + ins_pct + rem_pct)
                f = FUNC_REMOVE;
            else
                f = FUNC_FIND;
            queue_word(f, pick_key(home_lo, home_span), pick_value());
        end
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            in_gap_left = 0;
            for (int s = 0; s < TBL; s++)
                slot_st[s] = SLOT_EMPTY;
            live_cnt = 0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                fresh = table_apply(held_word);
                pending_results.push_back(fresh);
                words_accepted++;
                case (fresh.func)
                    FUNC_INSERT: begin
                        n_ins++;
                        if (fresh.table_full)
                            n_full++;
                        else if (!fresh.success)
                            n_dup++;
                    end
                    FUNC_FIND:   n_find++;
                    FUNC_REMOVE: n_rem++;
                    default:     n_unused++;
                endcase
                if (live_cnt > peak_live)
                    peak_live = live_cnt;
            end
            // a word on offer stays put until it is taken
            if (!i_in_valid || !o_in_stall) begin
                if (in_gap_left > 0) begin
                    in_gap_left--;
                    i_in_valid <= 1'b0;
                end else if (in_idle_pct != 0 && $urandom_range(0, 99) < in_idle_pct) begin
                    in_gap_left = $urandom_range(0, 14);
                    i_in_valid <= 1'b0;
                end else if (op_backlog.size() != 0) begin
                    held_word = op_backlog.pop_front();
                    i_in_valid <= 1'b1;
                    i_func <= held_word.func;
                    i_key <= held_word.key;
                    i_value <= held_word.value;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    task automatic report_mismatch(input string field, input logic [31:0] want,
                                   input logic [31:0] got);
        if (errors < MAX_REPORTS)
            $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
        errors++;
    endtask

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            out_gap_left = 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected result, live_entries", '0,
                                    32'(o_live_entries));
                end else begin
                    fresh = pending_results.pop_front();
                    n_checked++;
                    if (o_success !== fresh.success)
                        report_mismatch("success", 32'(fresh.success), 32'(o_success));
                    if (o_table_full !== fresh.table_full)
                        report_mismatch("table_full", 32'(fresh.table_full),
                                        32'(o_table_full));
                    if (o_found_value !== fresh.found_value)
                        report_mismatch("found_value", fresh.found_value, o_found_value);
                    if (o_live_entries !== fresh.live_entries)
                        report_mismatch("live_entries", 32'(fresh.live_entries),
                                        32'(o_live_entries));
                end
            end
            if (out_gap_left > 0) begin
                out_gap_left--;
                i_out_stall <= 1'b1;
            end else if (out_idle_pct != 0 && $urandom_range(0, 99) < out_idle_pct) begin
                out_gap_left = $urandom_range(0, 14);
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d words accepted of %0d, %0d results outstanding",
                     $time, words_accepted, words_queued, pending_results.size());
            $display("** linear_probe_hash_map: FAILED **");
            $finish;
        end
    end

    initial begin
        // directed corner cases
        queue_word(FUNC_FIND,   32'h0000_0000, 32'h0000_0000);  // empty table
        queue_word(FUNC_REMOVE, 32'hFFFF_FFFF, 32'h0000_0000);
        queue_word(FUNC_UNUSED, 32'h1234_5678, 32'h0000_0000);
        queue_word(FUNC_INSERT, 32'h0000_0000, 32'h7FFF_FFFF);
        queue_word(FUNC_INSERT, 32'h0000_0000, 32'hFFFF_FFFF);  // duplicate
        queue_word(FUNC_INSERT, 32'hFFFF_FFFF, 32'h8000_0000);  // last slot
        queue_word(FUNC_INSERT, 32'h7FFF_FFFF, 32'h0000_0001);  // wraps round to slot 1
        queue_word(FUNC_FIND,   32'h7FFF_FFFF, 32'h0000_0000);
        queue_word(FUNC_FIND,   32'hFFFF_FFFF, 32'h0000_0000);
        queue_word(FUNC_INSERT, 32'h0000_0040, 32'h0000_0040);  // home 0, lands in slot 2
        queue_word(FUNC_REMOVE, 32'h0000_0000, 32'h0000_0000);  // tombstone in slot 0
        queue_word(FUNC_INSERT, 32'h0000_0040, 32'h5555_5555);  // reuses tombstone: live twice
        queue_word(FUNC_FIND,   32'h0000_0040, 32'h0000_0000);  // nearer copy
        queue_word(FUNC_REMOVE, 32'h0000_0040, 32'h0000_0000);
        queue_word(FUNC_FIND,   32'h0000_0040, 32'h0000_0000);  // older copy further on
        queue_word(FUNC_FIND,   32'h0000_0000, 32'h0000_0000);  // absent, past tombstone
        queue_word(FUNC_REMOVE, 32'h0000_0000, 32'h0000_0000);
        queue_word(FUNC_INSERT, 32'hAAAA_AAAA, 32'h5555_5555);
        queue_word(FUNC_INSERT, 32'h5555_5555, 32'hAAAA_AAAA);
        queue_word(FUNC_FIND,   32'hAAAA_AAAA, 32'h0000_0000);
        queue_word(FUNC_FIND,   32'h5555_5555, 32'h0000_0000);
        queue_word(FUNC_UNUSED, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
        queue_word(FUNC_REMOVE, 32'hFFFF_FFFF, 32'h0000_0000);

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // hold the next word back until the directed run has fully answered
        wait_all_answered();

        run_phase(200,  0, TBL, 50, 20, 15, 15);
        run_phase(200, 60,   4, 55, 20,  0, 40);  // clusters wrapping past the end
        run_phase(250,  0, TBL, 85,  5, 40,  0);  // fill until inserts are refused
        run_phase(250,  0,   8, 10, 70, 10, 10);  // drain
        run_phase(250, 30,   2, 45, 40,  0,  0);  // tombstone churn on two homes
        run_phase(200,  0, TBL, 80, 10, 25, 25);
        run_phase(250, 50,  16, 40, 35,  5, 30);
        wait_all_answered();
        run_phase(200,  0, TBL, 45, 30,  0,  0);
        wait_all_answered();
        repeat (TAIL_CYCLES) @(negedge i_clk);

        $display("Ran %0d words: %0d inserts (%0d duplicates, %0d refused as full), %0d finds,",
                 words_accepted, n_ins, n_dup, n_full, n_find);
        $display("%0d removes, %0d unused codes; peak occupancy %0d/%0d, %0d results checked",
                 n_rem, n_unused, peak_live, TBL, n_checked);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("** linear_probe_hash_map: PASSED **");
        end else begin
            $display("%0d mismatches", errors);
            $display("** linear_probe_hash_map: FAILED **");
        end
        $finish;
    end

endmodule
